// ===== hdl/potential_field_velocity_command_unit_macros.svh =====
// Assertion macros for the potential field velocity command unit.
`ifndef POTENTIAL_FIELD_VELOCITY_COMMAND_UNIT_MACROS_SVH
`define POTENTIAL_FIELD_VELOCITY_COMMAND_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define PFVC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
// Next-cycle implication, checked outside reset.
`define PFVC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define PFVC_ASSERT_IMPL(lbl, ante, cons)
`define PFVC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/pfvc_pkg.sv =====
// Package with types and constants of the potential field velocity command unit.
`timescale 1ns / 1ps
package pfvc_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Iteration counts of the shared arithmetic units.
  localparam int MUL_STEPS  = 32;
  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 33;

  // Configuration register indexes.
  localparam logic [2:0] REG_TARGET_X  = 3'd0;
  localparam logic [2:0] REG_TARGET_Y  = 3'd1;
  localparam logic [2:0] REG_MAX_SPEED = 3'd2;
  localparam logic [2:0] REG_SAFE_DIST = 3'd3;
  localparam logic [2:0] REG_ARRIVAL   = 3'd4;
  localparam logic [2:0] REG_GAIN      = 3'd5;

  // Sequencer states.
  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_OBS  = 14'b00000000000010,
    S_LAST = 14'b00000000000100,
    S_SQX  = 14'b00000000001000,
    S_SQY  = 14'b00000000010000,
    S_SQRT = 14'b00000000100000,
    S_GAIN = 14'b00000001000000,
    S_RMUL = 14'b00000010000000,
    S_RDIV = 14'b00000100000000,
    S_MULX = 14'b00001000000000,
    S_DIVX = 14'b00010000000000,
    S_MULY = 14'b00100000000000,
    S_DIVY = 14'b01000000000000,
    S_OUT  = 14'b10000000000000
  } state_t;

  // Which vector the distance and scaling chain is working on.
  typedef enum logic [2:0] {
    PH_ATTR  = 3'b001,
    PH_REP   = 3'b010,
    PH_FINAL = 3'b100
  } phase_t;

endpackage

// ===== hdl/potential_field_velocity_command_unit.sv =====
// Potential field velocity command unit: sequencer with shared multiply, divide and root units.
`timescale 1ns / 1ps
`include "potential_field_velocity_command_unit_macros.svh"
// Use: a control tick arrives as a run of requests on the in_valid/in_ready
// channel; each request carries the position, at most one obstacle and a
// last mark. The first request of a tick latches the position and loads the
// attraction velocity toward the target; each request with an obstacle inside
// the safe distance adds a repulsion; the last request clamps the speed and
// sends one result (vel_x, vel_y, arrived) on out_valid/out_ready.
// Registers are to be written over the APB port only while the block is idle;
// the block itself does not enforce this. It takes one request at a time,
// paced by the bit-serial units: a 32-step multiplier, a 64-step divider
// and a 33-step square root, one running at a time under the sequencer.
// A finished result sits in the output register; the next request is taken
// while it waits, and the block stalls only when a second result is ready
// before the first is taken. Reset restores the register defaults, ends any
// open tick and drops any pending result.
module potential_field_velocity_command_unit
  import pfvc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] obs_x,
  input  logic signed [31:0] obs_y,
  input  logic               obs_valid,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic               arrived
);

  localparam logic [31:0] TARGET_RST = 32'(10 << FRAC_BITS);
  localparam logic [30:0] MAX_RST    = 31'(5 << FRAC_BITS);
  localparam logic [30:0] SAFE_RST   = 31'(2 << FRAC_BITS);
  localparam logic [30:0] ARR_RST    = 31'(1 << (FRAC_BITS - 1));
  localparam logic [20:0] GAIN_RST   = 21'(1 << (FRAC_BITS - 1));

  // Configuration registers.
  logic signed [31:0] target_x, target_y;
  logic [30:0] speed_cap, safe_rad, arrive_rad;
  logic [20:0] approach_gain;

  // Tick state.
  logic signed [31:0] acc_vx, acc_vy, held_x, held_y;
  logic in_tick, arrived_flag;

  // Latched request.
  logic signed [31:0] obs_x_l, obs_y_l;
  logic obs_v_l, last_l;

  // Working registers of the chain.
  state_t state;
  phase_t phase;
  logic [31:0] ux, uy;
  logic sx, sy;
  logic [33:0] norm_len;
  logic [30:0] factor;
  logic [65:0] sum_sq;
  logic signed [31:0] res_x;

  // Shared unit registers.
  logic [5:0]  cnt;
  logic [65:0] mul_acc, mul_a;
  logic [31:0] mul_b;
  logic [63:0] div_q;
  logic [33:0] div_r, div_d;
  logic [65:0] sq_rad;
  logic [35:0] sq_rem;
  logic [32:0] sq_root;

  // Unit next values.
  logic [65:0] mul_acc_next;
  logic [34:0] div_t, div_diff;
  logic        div_ge;
  logic [33:0] div_r_next;
  logic [63:0] div_q_next;
  logic [35:0] sq_t, sq_trial;
  logic        sq_ge;
  logic [35:0] sq_rem_next;
  logic [32:0] sq_root_next;

  // Helpers for the request path.
  logic signed [32:0] dx, dy, rx, ry;
  logic [65:0] gain_spd;
  logic signed [31:0] res_y;
  logic mul_done, div_done, sq_done;

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic signed [32:0] n;
    n = -v;
    return v[32] ? n[31:0] : v[31:0];
  endfunction

  function automatic logic signed [31:0] with_sign(input logic [31:0] q, input logic s);
    return s ? 32'(-q) : q;
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s > 33'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (s < -33'sd2147483648) begin
      return 32'sh80000000;
    end
    return s[31:0];
  endfunction

  // APB port.
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[4:2])
      REG_TARGET_X:  prdata = target_x;
      REG_TARGET_Y:  prdata = target_y;
      REG_MAX_SPEED: prdata = {1'b0, speed_cap};
      REG_SAFE_DIST: prdata = {1'b0, safe_rad};
      REG_ARRIVAL:   prdata = {1'b0, arrive_rad};
      REG_GAIN:      prdata = {11'b0, approach_gain};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x      <= TARGET_RST;
      target_y      <= TARGET_RST;
      speed_cap     <= MAX_RST;
      safe_rad      <= SAFE_RST;
      arrive_rad    <= ARR_RST;
      approach_gain <= GAIN_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[4:2])
        REG_TARGET_X:  target_x <= pwdata;
        REG_TARGET_Y:  target_y <= pwdata;
        REG_MAX_SPEED: speed_cap <= pwdata[30:0];
        REG_SAFE_DIST: safe_rad <= pwdata[30:0];
        REG_ARRIVAL:   arrive_rad <= pwdata[30:0];
        REG_GAIN:      approach_gain <= pwdata[20:0];
        default: ;
      endcase
    end
  end

  // One step of the shift-add multiplier, restoring divider and square root.
  always_comb begin
    mul_acc_next = mul_b[0] ? mul_acc + mul_a : mul_acc;
    div_t        = {div_r, div_q[63]};
    div_diff     = div_t - {1'b0, div_d};
    div_ge       = div_t >= {1'b0, div_d};
    div_r_next   = div_ge ? div_diff[33:0] : div_t[33:0];
    div_q_next   = {div_q[62:0], div_ge};
    sq_t         = {sq_rem[33:0], sq_rad[65:64]};
    sq_trial     = {1'b0, sq_root, 2'b01};
    sq_ge        = sq_t >= sq_trial;
    sq_rem_next  = sq_ge ? sq_t - sq_trial : sq_t;
    sq_root_next = {sq_root[31:0], sq_ge};
  end

  assign mul_done = cnt == 6'(MUL_STEPS - 1);
  assign div_done = cnt == 6'(DIV_STEPS - 1);
  assign sq_done  = cnt == 6'(SQRT_STEPS - 1);

  // Difference vectors for attraction and repulsion.
  assign dx = {target_x[31], target_x} - {pos_x[31], pos_x};
  assign dy = {target_y[31], target_y} - {pos_y[31], pos_y};
  assign rx = {held_x[31], held_x} - {obs_x_l[31], obs_x_l};
  assign ry = {held_y[31], held_y} - {obs_y_l[31], obs_y_l};
  assign gain_spd = mul_acc_next >> FRAC_BITS;
  assign res_y = with_sign(div_q_next[31:0], sy);

  assign in_ready = state == S_IDLE;

  // Sequencer and data path.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_ATTR;
      in_tick      <= 1'b0;
      arrived_flag <= 1'b0;
      acc_vx       <= '0;
      acc_vy       <= '0;
      held_x       <= '0;
      held_y       <= '0;
      out_valid    <= 1'b0;
      cnt          <= '0;
    end else begin
      // The units step every cycle; a launch below overrides.
      cnt     <= cnt + 6'd1;
      mul_acc <= mul_acc_next;
      mul_a   <= {mul_a[64:0], 1'b0};
      mul_b   <= {1'b0, mul_b[31:1]};
      div_q   <= div_q_next;
      div_r   <= div_r_next;
      sq_rad  <= {sq_rad[63:0], 2'b00};
      sq_rem  <= sq_rem_next;
      sq_root <= sq_root_next;

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            obs_x_l <= obs_x;
            obs_y_l <= obs_y;
            obs_v_l <= obs_valid;
            last_l  <= last;
            if (!in_tick) begin
              held_x  <= pos_x;
              held_y  <= pos_y;
              ux      <= mag33(dx);
              uy      <= mag33(dy);
              sx      <= dx[32];
              sy      <= dy[32];
              phase   <= PH_ATTR;
              mul_acc <= '0;
              mul_a   <= 66'(mag33(dx));
              mul_b   <= mag33(dx);
              cnt     <= '0;
              state   <= S_SQX;
            end else begin
              state <= S_OBS;
            end
          end
        end
        S_OBS: begin
          if (obs_v_l) begin
            ux      <= mag33(rx);
            uy      <= mag33(ry);
            sx      <= rx[32];
            sy      <= ry[32];
            phase   <= PH_REP;
            mul_acc <= '0;
            mul_a   <= 66'(mag33(rx));
            mul_b   <= mag33(rx);
            cnt     <= '0;
            state   <= S_SQX;
          end else begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          if (last_l) begin
            ux      <= mag33({acc_vx[31], acc_vx});
            uy      <= mag33({acc_vy[31], acc_vy});
            sx      <= acc_vx[31];
            sy      <= acc_vy[31];
            phase   <= PH_FINAL;
            mul_acc <= '0;
            mul_a   <= 66'(mag33({acc_vx[31], acc_vx}));
            mul_b   <= mag33({acc_vx[31], acc_vx});
            cnt     <= '0;
            state   <= S_SQX;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SQX: begin
          if (mul_done) begin
            sum_sq  <= mul_acc_next;
            mul_acc <= '0;
            mul_a   <= 66'(uy);
            mul_b   <= uy;
            cnt     <= '0;
            state   <= S_SQY;
          end
        end
        S_SQY: begin
          if (mul_done) begin
            sq_rad  <= sum_sq + mul_acc_next;
            sq_rem  <= '0;
            sq_root <= '0;
            cnt     <= '0;
            state   <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            norm_len <= {1'b0, sq_root_next};
            unique case (phase)
              PH_ATTR: begin
                in_tick      <= 1'b1;
                arrived_flag <= sq_root_next < {2'b0, arrive_rad};
                acc_vx       <= '0;
                acc_vy       <= '0;
                if (sq_root_next >= {2'b0, arrive_rad} && sq_root_next != '0) begin
                  mul_acc <= '0;
                  mul_a   <= 66'(sq_root_next);
                  mul_b   <= {11'b0, approach_gain};
                  cnt     <= '0;
                  state   <= S_GAIN;
                end else begin
                  state <= S_OBS;
                end
              end
              PH_REP: begin
                if (sq_root_next < {2'b0, safe_rad} && sq_root_next != '0) begin
                  mul_acc <= '0;
                  mul_a   <= 66'(safe_rad - sq_root_next[30:0]);
                  mul_b   <= {1'b0, speed_cap};
                  cnt     <= '0;
                  state   <= S_RMUL;
                end else begin
                  state <= S_LAST;
                end
              end
              PH_FINAL: begin
                if (sq_root_next > {2'b0, speed_cap}) begin
                  factor  <= speed_cap;
                  mul_acc <= '0;
                  mul_a   <= 66'(ux);
                  mul_b   <= {1'b0, speed_cap};
                  cnt     <= '0;
                  state   <= S_MULX;
                end else begin
                  res_x  <= acc_vx;
                  sum_sq <= 66'(unsigned'(acc_vy));
                  state  <= S_OUT;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_GAIN: begin
          if (mul_done) begin
            // Approach speed is the gain times distance, limited to max speed.
            if (gain_spd > 66'(speed_cap)) begin
              factor <= speed_cap;
              mul_b  <= {1'b0, speed_cap};
            end else begin
              factor <= gain_spd[30:0];
              mul_b  <= {1'b0, gain_spd[30:0]};
            end
            mul_acc <= '0;
            mul_a   <= 66'(ux);
            cnt     <= '0;
            state   <= S_MULX;
          end
        end
        S_RMUL: begin
          if (mul_done) begin
            div_q <= mul_acc_next[63:0];
            div_r <= '0;
            div_d <= {3'b0, safe_rad};
            cnt   <= '0;
            state <= S_RDIV;
          end
        end
        S_RDIV: begin
          if (div_done) begin
            factor  <= div_q_next[30:0];
            mul_acc <= '0;
            mul_a   <= 66'(ux);
            mul_b   <= {1'b0, div_q_next[30:0]};
            cnt     <= '0;
            state   <= S_MULX;
          end
        end
        S_MULX, S_MULY: begin
          if (mul_done) begin
            div_q <= mul_acc_next[63:0];
            div_r <= '0;
            div_d <= norm_len;
            cnt   <= '0;
            state <= (state == S_MULX) ? S_DIVX : S_DIVY;
          end
        end
        S_DIVX: begin
          if (div_done) begin
            res_x   <= with_sign(div_q_next[31:0], sx);
            mul_acc <= '0;
            mul_a   <= 66'(uy);
            mul_b   <= {1'b0, factor};
            cnt     <= '0;
            state   <= S_MULY;
          end
        end
        S_DIVY: begin
          if (div_done) begin
            unique case (phase)
              PH_ATTR: begin
                acc_vx <= res_x;
                acc_vy <= res_y;
                state  <= S_OBS;
              end
              PH_REP: begin
                acc_vx <= sat_add(acc_vx, res_x);
                acc_vy <= sat_add(acc_vy, res_y);
                state  <= S_LAST;
              end
              PH_FINAL: begin
                sum_sq <= 66'(unsigned'(res_y));
                state  <= S_OUT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_OUT: begin
          // Wait until the output register is free.
          if (!out_valid || out_ready) begin
            vel_x     <= res_x;
            vel_y     <= sum_sq[31:0];
            arrived   <= arrived_flag;
            out_valid <= 1'b1;
            in_tick   <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A request keeps the block busy for at least the next cycle.
  `PFVC_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)
  // A result is only sent from within an open tick.
  `PFVC_ASSERT_IMPL(a_out_in_tick, state == S_OUT, in_tick)
  // The first request of a tick latches its position.
  `PFVC_ASSERT_NEXT(a_pos_latched, in_valid && in_ready && !in_tick, held_x == $past(pos_x) && held_y == $past(pos_y))

endmodule
